// File: hdl/hex_record_line_parser_top_defines.svh
// ----------------------------------------------------------------------------
// hex record line parser assertion macros
// implication checks that are compiled in for simulation and empty for synthesis
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_LINE_PARSER_TOP_DEFINES_SVH
`define HEX_RECORD_LINE_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define HRLP_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

`define HRLP_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HRLP_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons, msg)

`define HRLP_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

// File: hdl/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// shared types, character constants and the nibble conversion of the parser
// ----------------------------------------------------------------------------
`default_nettype none

package hrlp_pkg;

    typedef enum logic [1:0]
    {
        PH_WAIT,
        PH_HEADER,
        PH_DATA,
        PH_DONE
    } phase_t;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_F    = 8'h66;
    localparam logic [7:0] CASE_GAP   = 8'd32;
    localparam logic [3:0] HEX_TEN    = 4'd10;

    localparam logic [1:0] HDR_LENGTH    = 2'd0;
    localparam logic [1:0] HDR_OFFSET_HI = 2'd1;
    localparam logic [1:0] HDR_OFFSET_LO = 2'd2;
    localparam logic [1:0] HDR_TYPE      = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed
    {
        logic [7:0]  data_byte;
        logic        has_data;
        logic [7:0]  byte_index;
        logic [7:0]  record_length;
        logic [15:0] load_offset;
        logic [7:0]  record_kind;
        logic        last;
    } result_t;

    function automatic logic [3:0] char_to_nibble(input logic [7:0] c);
        logic [7:0] v;
        logic [3:0] n;
        v = c;
        if ((c >= LOWER_A) && (c <= LOWER_F))
        begin
            v = c - CASE_GAP;
        end
        if (v <= DIGIT_NINE)
        begin
            n = v[3:0] - DIGIT_ZERO[3:0];
        end
        else
        begin
            n = v[3:0] - UPPER_A[3:0] + HEX_TEN;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hdl/hrlp_parser.sv
// ----------------------------------------------------------------------------
// hrlp_parser
// record state machine: pairs nibbles into bytes, keeps header, forms results
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_parser
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire logic [7:0]      character,
    output logic                 res_push,
    output hrlp_pkg::result_t    res_data
);
    import hrlp_pkg::*;

    phase_t      phase_reg,          phase_next;
    logic        pending_reg,        pending_next;
    logic [3:0]  high_nibble_reg,    high_nibble_next;
    logic [1:0]  hdr_count_reg,      hdr_count_next;
    logic [7:0]  length_reg,         length_next;
    logic [15:0] offset_reg,         offset_next;
    logic [7:0]  type_reg,           type_next;
    logic [7:0]  data_count_reg,     data_count_next;

    logic [7:0]  byte_val;
    logic        byte_done;
    logic        is_colon;
    logic        in_record;
    logic        last_data;

    assign is_colon  = (character == COLON_CHAR);
    assign in_record = (phase_reg == PH_HEADER) || (phase_reg == PH_DATA);
    assign byte_val  = {high_nibble_reg, char_to_nibble(character)};
    assign byte_done = take && !is_colon && in_record && pending_reg;
    assign last_data = ({1'b0, data_count_reg} + 9'd1) == {1'b0, length_reg};

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        pending_next     = pending_reg;
        high_nibble_next = high_nibble_reg;
        hdr_count_next   = hdr_count_reg;
        length_next      = length_reg;
        offset_next      = offset_reg;
        type_next        = type_reg;
        data_count_next  = data_count_reg;
        if (take)
        begin
            if (is_colon)
            begin
                phase_next       = PH_HEADER;
                pending_next     = 1'b0;
                high_nibble_next = 4'd0;
                hdr_count_next   = 2'd0;
                length_next      = 8'd0;
                offset_next      = 16'd0;
                type_next        = 8'd0;
                data_count_next  = 8'd0;
            end
            else if (in_record && !pending_reg)
            begin
                high_nibble_next = char_to_nibble(character);
                pending_next     = 1'b1;
            end
            else if (in_record)
            begin
                pending_next = 1'b0;
                if (phase_reg == PH_HEADER)
                begin
                    unique case (hdr_count_reg)
                        HDR_LENGTH:    length_next = byte_val;
                        HDR_OFFSET_HI: offset_next = {byte_val, offset_reg[7:0]};
                        HDR_OFFSET_LO: offset_next = {offset_reg[15:8], byte_val};
                        HDR_TYPE:      type_next   = byte_val;
                        default:       type_next   = byte_val;
                    endcase
                    hdr_count_next = hdr_count_reg + 2'd1;
                    if (hdr_count_reg == HDR_TYPE)
                    begin
                        data_count_next = 8'd0;
                        phase_next      = (length_reg == 8'd0) ? PH_DONE : PH_DATA;
                    end
                end
                else
                begin
                    data_count_next = data_count_reg + 8'd1;
                    if (last_data)
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
        end
    end

    // result
    always_comb
    begin
        res_push               = 1'b0;
        res_data.data_byte     = 8'd0;
        res_data.has_data      = 1'b0;
        res_data.byte_index    = 8'd0;
        res_data.record_length = length_reg;
        res_data.load_offset   = offset_reg;
        res_data.record_kind   = type_reg;
        res_data.last          = 1'b0;
        if (byte_done)
        begin
            if (phase_reg == PH_HEADER)
            begin
                if ((hdr_count_reg == HDR_TYPE) && (length_reg == 8'd0))
                begin
                    res_push             = 1'b1;
                    res_data.record_kind = byte_val;
                    res_data.last        = 1'b1;
                end
            end
            else
            begin
                res_push            = 1'b1;
                res_data.data_byte  = byte_val;
                res_data.has_data   = 1'b1;
                res_data.byte_index = data_count_reg;
                res_data.last       = last_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            pending_reg     <= 1'b0;
            high_nibble_reg <= 4'd0;
            hdr_count_reg   <= 2'd0;
            length_reg      <= 8'd0;
            offset_reg      <= 16'd0;
            type_reg        <= 8'd0;
            data_count_reg  <= 8'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            pending_reg     <= pending_next;
            high_nibble_reg <= high_nibble_next;
            hdr_count_reg   <= hdr_count_next;
            length_reg      <= length_next;
            offset_reg      <= offset_next;
            type_reg        <= type_next;
            data_count_reg  <= data_count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/hrlp_out_queue.sv
// ----------------------------------------------------------------------------
// hrlp_out_queue
// two-entry result register with skid slot on the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_out_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hrlp_pkg::result_t push_data,
    output logic                   full,
    output logic                   head_valid,
    input  wire logic              head_stall,
    output hrlp_pkg::result_t      head_data
);
    import hrlp_pkg::*;

    logic [1:0] count_reg,  count_next;
    result_t    slot0_reg,  slot0_next;
    result_t    slot1_reg,  slot1_next;
    logic       pop;

    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'(QUEUE_DEPTH));
    assign head_data  = slot0_reg;
    assign pop        = head_valid && !head_stall;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        unique case ({push, pop})
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    slot0_next = push_data;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = push_data;
                end
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    slot0_next = push_data;
                end
                else
                begin
                    slot1_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// File: hdl/hex_record_line_parser_top.sv
// ----------------------------------------------------------------------------
// hex_record_line_parser_top
// parses hex record text one character per transfer into data byte results
//
//   channel   direction  handshake                    payload
//   text      in         text_valid / text_stall      character
//   result    out        result_valid / result_stall  data_byte .. last
//
// one character per cycle while text_stall is low; a result reaches the output
// through the input register, then the parser into the output register
// the parser state is registered and updates from the registered character
// reset clears the parser to waiting for a colon and empties the output queue
// text_stall rises only while both output entries hold results not yet taken
// ----------------------------------------------------------------------------
`default_nettype none

`include "hex_record_line_parser_top_defines.svh"

module hex_record_line_parser_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        text_valid,
    output logic             text_stall,
    input  wire logic [7:0]  character,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       data_byte,
    output logic             has_data,
    output logic [7:0]       byte_index,
    output logic [7:0]       record_length,
    output logic [15:0]      load_offset,
    output logic [7:0]       record_kind,
    output logic             last
);
    import hrlp_pkg::*;

    logic       hold_valid_reg;
    logic [7:0] hold_char_reg;
    logic       q_full;
    logic       take;
    logic       res_push;
    result_t    res_data;
    result_t    head_data;

    assign text_stall = hold_valid_reg && q_full;
    assign take       = hold_valid_reg && !q_full;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            hold_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall)
        begin
            hold_char_reg <= character;
        end
    end

    hrlp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .character (hold_char_reg),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    hrlp_out_queue u_out_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_push),
        .push_data  (res_data),
        .full       (q_full),
        .head_valid (result_valid),
        .head_stall (result_stall),
        .head_data  (head_data)
    );

    assign data_byte     = head_data.data_byte;
    assign has_data      = head_data.has_data;
    assign byte_index    = head_data.byte_index;
    assign record_length = head_data.record_length;
    assign load_offset   = head_data.load_offset;
    assign record_kind   = head_data.record_kind;
    assign last          = head_data.last;

    `HRLP_ASSERT_IMPLY(a_last_matches_index, clk, rst_n, result_valid && has_data, last == ((byte_index + 8'd1) == record_length), "last flag disagrees with byte index")
    `HRLP_ASSERT_IMPLY(a_empty_record_form, clk, rst_n, result_valid && !has_data, last && (record_length == 8'd0) && (data_byte == 8'd0) && (byte_index == 8'd0), "header-only result malformed")
    `HRLP_ASSERT_IMPLY(a_stall_needs_backlog, clk, rst_n, text_stall, result_valid, "text stalled with no result waiting")
    `HRLP_ASSERT_NEXT(a_backlog_moves, clk, rst_n, result_valid && !result_stall && !text_valid && !hold_valid_reg, !text_stall, "stall held after output drained")

endmodule

`default_nettype wire
